### rtl/apu_fss_pkg.sv
package apu_fss_pkg;

  // Default number of length counter channels.
  localparam int NUM_LEN_CH_DEFAULT = 4;

  // Channels that have register access and status bits.
  localparam int REG_CHANNELS = 4;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Register offsets from the APU base.
  localparam logic [4:0] REG_DMC_CTRL = 5'h10;
  localparam logic [4:0] REG_DMC_LEN  = 5'h13;
  localparam logic [4:0] REG_STATUS   = 5'h15;
  localparam logic [4:0] REG_FRAME    = 5'h17;

  // Low two address bits inside a channel's register group.
  localparam logic [1:0] CH_REG_HALT = 2'd0;
  localparam logic [1:0] CH_REG_LEN  = 2'd3;

  // Frame sequencer points.
  localparam logic [15:0] FC_STEP1     = 16'd14913;
  localparam logic [15:0] FC4_STEP2    = 16'd29829;
  localparam logic [15:0] FC4_IRQ_FROM = 16'd29828;
  localparam logic [15:0] FC4_WRAP     = 16'd29830;
  localparam logic [15:0] FC5_STEP2    = 16'd37281;
  localparam logic [15:0] FC5_WRAP     = 16'd37282;

  // Frame restart delay after a frame register write.
  localparam logic [2:0] FRAME_DELAY_EVEN = 3'd3;
  localparam logic [2:0] FRAME_DELAY_ODD  = 3'd4;

  // Sample channel reset values.
  localparam logic [8:0] DMC_PERIOD_RESET = 9'h1AC;
  localparam logic [3:0] DMC_BITS_PER_BYTE = 4'd8;

  // Length counter load table.
  localparam logic [7:0] LEN_TABLE [32] = '{
    8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
    8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
    8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
    8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E
  };

  // Sample channel period table.
  localparam logic [8:0] PERIOD_TABLE [16] = '{
    9'h1AC, 9'h17C, 9'h154, 9'h140, 9'h11E, 9'h0FE, 9'h0E2, 9'h0D6,
    9'h0BE, 9'h0A0, 9'h08E, 9'h080, 9'h06A, 9'h054, 9'h048, 9'h036
  };

  // Input item.
  typedef struct packed {
    logic [1:0] command;
    logic [4:0] reg_address;
    logic [7:0] write_data;
  } apu_in_t;

  // Result item.
  typedef struct packed {
    logic [7:0] read_data;
    logic       frame_irq;
    logic       sample_irq;
    logic       sample_fetch;
  } apu_out_t;

  // Strobes from the top level to the sample channel, valid on a transfer only.
  typedef struct packed {
    logic tick;
    logic wr_ctrl;
    logic wr_len;
    logic wr_status;
  } smp_ctl_t;

  // Sample channel status back to the top level.
  typedef struct packed {
    logic active;
    logic irq;
    logic irq_nxt;
    logic fetch;
  } smp_stat_t;

endpackage

### rtl/apu_fss_sample.sv
module apu_fss_sample import apu_fss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  smp_ctl_t  ctl,
  input  logic [7:0] wdata,
  output smp_stat_t stat
);

  logic [11:0] bytes_left_r, bytes_left_nxt;
  logic [11:0] length_r, length_nxt;
  logic [8:0]  period_r, period_nxt;
  logic [8:0]  reload_r, reload_nxt;
  logic [3:0]  bits_left_r, bits_left_nxt;
  logic        loop_r, loop_nxt;
  logic        irq_en_r, irq_en_nxt;
  logic        empty_r, empty_nxt;
  logic        irq_r, irq_nxt;

  logic        fetch;
  logic [11:0] fetch_src;
  logic [11:0] fetch_rem;
  logic [8:0]  period_dec;
  logic [3:0]  bits_dec;

  // Period timer, bit timer, register writes and the byte fetch.
  always_comb begin
    bytes_left_nxt = bytes_left_r;
    length_nxt     = length_r;
    period_nxt     = period_r;
    reload_nxt     = reload_r;
    bits_left_nxt  = bits_left_r;
    loop_nxt       = loop_r;
    irq_en_nxt     = irq_en_r;
    empty_nxt      = empty_r;
    irq_nxt        = irq_r;
    fetch          = 1'b0;
    fetch_src      = bytes_left_r;
    period_dec     = period_r - 9'd1;
    bits_dec       = bits_left_r - 4'd1;

    if (ctl.tick) begin
      period_nxt = period_dec;
      if (period_dec == 9'd0) begin
        period_nxt    = reload_r;
        bits_left_nxt = bits_dec;
        if (bits_dec == 4'd0) begin
          bits_left_nxt = DMC_BITS_PER_BYTE;
          empty_nxt     = 1'b1;
          fetch         = (bytes_left_r != 12'd0);
        end
      end
    end

    if (ctl.wr_ctrl) begin
      irq_en_nxt = wdata[7];
      loop_nxt   = wdata[6];
      reload_nxt = PERIOD_TABLE[wdata[3:0]];
      if (!wdata[7]) begin
        irq_nxt = 1'b0;
      end
    end

    if (ctl.wr_len) begin
      length_nxt = {wdata, 4'b0000} + 12'd1;
    end

    if (ctl.wr_status) begin
      irq_nxt = 1'b0;
      if (!wdata[4]) begin
        bytes_left_nxt = 12'd0;
      end else if (bytes_left_r == 12'd0) begin
        bytes_left_nxt = length_r;
        fetch_src      = length_r;
        fetch          = empty_r && (length_r != 12'd0);
      end
    end

    // A fetch takes one byte; on the last byte it loops, or raises an interrupt if enabled.
    fetch_rem = fetch_src - 12'd1;
    if (fetch) begin
      empty_nxt      = 1'b0;
      bytes_left_nxt = fetch_rem;
      if (fetch_rem == 12'd0) begin
        if (loop_r) begin
          bytes_left_nxt = length_r;
        end else if (irq_en_r) begin
          irq_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      length_r     <= '0;
      period_r     <= DMC_PERIOD_RESET;
      reload_r     <= DMC_PERIOD_RESET;
      bits_left_r  <= DMC_BITS_PER_BYTE;
      loop_r       <= 1'b0;
      irq_en_r     <= 1'b0;
      empty_r      <= 1'b1;
      irq_r        <= 1'b0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      length_r     <= length_nxt;
      period_r     <= period_nxt;
      reload_r     <= reload_nxt;
      bits_left_r  <= bits_left_nxt;
      loop_r       <= loop_nxt;
      irq_en_r     <= irq_en_nxt;
      empty_r      <= empty_nxt;
      irq_r        <= irq_nxt;
    end
  end

  assign stat.active  = (bytes_left_r != 12'd0);
  assign stat.irq     = irq_r;
  assign stat.irq_nxt = irq_nxt;
  assign stat.fetch   = fetch;

endmodule

### rtl/apu_frame_sequencer_status_unit.sv
// Channel  | Ports                          | Moves
// ---------+--------------------------------+-----------------------------------
// input    | in_valid, in_ready, in_data    | one tick, write, read or no-op per transfer
// result   | out_valid, out_ready, out_data | one result per input item
//
// One item per clock is sustained while the result side keeps taking results; each
// item passes an input register and a result register before its result is offered.
// The state update for an item is a single pass of logic between those registers.
// rst_n is synchronous; after reset both stages are empty and all state is reset.
// A stalled result holds in the output register; the input register keeps taking
// items while it is empty or the output register frees up in the same cycle.
module apu_frame_sequencer_status_unit import apu_fss_pkg::*; #(
  parameter int NUM_LENGTH_CHANNELS = NUM_LEN_CH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  apu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output apu_out_t out_data
);

  localparam int NUM_STATUS = (NUM_LENGTH_CHANNELS < REG_CHANNELS) ?
                              NUM_LENGTH_CHANNELS : REG_CHANNELS;

  // Handshake and stage registers.
  logic     s1_valid_r;
  apu_in_t  s1_r;
  logic     out_valid_r;
  apu_out_t out_r, out_nxt;
  logic     out_free;
  logic     fire;

  assign out_free  = !out_valid_r || out_ready;
  assign fire      = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  // Command decode for the item in the input register.
  logic       is_tick, is_wr, is_rd;
  logic [7:0] wd;
  logic [4:0] addr;

  assign wd   = s1_r.write_data;
  assign addr = s1_r.reg_address;

  always_comb begin
    is_tick = 1'b0;
    is_wr   = 1'b0;
    is_rd   = 1'b0;
    unique case (cmd_e'(s1_r.command))
      CMD_TICK:  is_tick = fire;
      CMD_WRITE: is_wr   = fire;
      CMD_READ:  is_rd   = fire;
      CMD_NOP:   ;
    endcase
  end

  logic wr_frame, wr_status, rd_status;
  assign wr_frame  = is_wr && (addr == REG_FRAME);
  assign wr_status = is_wr && (addr == REG_STATUS);
  assign rd_status = is_rd && (addr == REG_STATUS);

  // Frame sequencer state.
  logic [15:0] fc_r, fc_nxt;
  logic [2:0]  delay_r, delay_nxt;
  logic        odd_r, odd_nxt;
  logic        five_r, five_nxt;
  logic        inhibit_r, inhibit_nxt;
  logic        fflag_r, fflag_nxt;
  logic        half_clk;
  logic        restarted;
  logic [15:0] fc_inc;

  // Tick advance, delayed restart, frame register write and status read clear.
  always_comb begin
    fc_nxt      = fc_r;
    delay_nxt   = delay_r;
    odd_nxt     = odd_r;
    five_nxt    = five_r;
    inhibit_nxt = inhibit_r;
    fflag_nxt   = fflag_r;
    half_clk    = 1'b0;
    restarted   = (delay_r == 3'd1);
    fc_inc      = fc_r + 16'd1;

    if (is_tick) begin
      odd_nxt = !odd_r;
      if (delay_r != 3'd0) begin
        delay_nxt = delay_r - 3'd1;
      end
      fc_nxt = restarted ? 16'd0 : fc_inc;
      if (five_r) begin
        if (!restarted && (fc_inc == FC5_WRAP)) begin
          fc_nxt = 16'd0;
        end
        half_clk = (fc_nxt == FC_STEP1) || (fc_nxt == FC5_STEP2);
      end else begin
        if (!restarted && (fc_inc == FC4_WRAP)) begin
          fc_nxt = 16'd0;
          if (!inhibit_r) begin
            fflag_nxt = 1'b1;
          end
        end
        half_clk = (fc_nxt == FC_STEP1) || (fc_nxt == FC4_STEP2);
        if ((fc_nxt >= FC4_IRQ_FROM) && !inhibit_r) begin
          fflag_nxt = 1'b1;
        end
      end
    end

    if (wr_frame) begin
      five_nxt    = wd[7];
      inhibit_nxt = wd[6];
      if (wd[6]) begin
        fflag_nxt = 1'b0;
      end
      delay_nxt = odd_r ? FRAME_DELAY_ODD : FRAME_DELAY_EVEN;
      half_clk  = wd[7];
    end

    if (rd_status) begin
      fflag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r      <= '0;
      delay_r   <= '0;
      odd_r     <= 1'b0;
      five_r    <= 1'b0;
      inhibit_r <= 1'b0;
      fflag_r   <= 1'b0;
    end else begin
      fc_r      <= fc_nxt;
      delay_r   <= delay_nxt;
      odd_r     <= odd_nxt;
      five_r    <= five_nxt;
      inhibit_r <= inhibit_nxt;
      fflag_r   <= fflag_nxt;
    end
  end

  // Length counters, one per channel; only the first four have register access.
  logic [7:0] len_r  [NUM_LENGTH_CHANNELS];
  logic       on_r   [NUM_LENGTH_CHANNELS];
  logic       halt_r [NUM_LENGTH_CHANNELS];
  logic       ch_group;

  assign ch_group = is_wr && (addr[4] == 1'b0);

  for (genvar c = 0; c < NUM_LENGTH_CHANNELS; c++) begin : g_len
    logic [7:0] len_nxt;
    logic       on_nxt;
    logic       halt_nxt;
    logic       sel;

    assign sel = ch_group && (int'(addr[3:2]) == c);

    always_comb begin
      len_nxt  = len_r[c];
      on_nxt   = on_r[c];
      halt_nxt = halt_r[c];
      if (half_clk && !halt_r[c] && (len_r[c] != 8'd0)) begin
        len_nxt = len_r[c] - 8'd1;
      end
      if (sel && (addr[1:0] == CH_REG_HALT)) begin
        halt_nxt = (c == 2) ? wd[7] : wd[5];
      end
      if (sel && (addr[1:0] == CH_REG_LEN) && on_r[c]) begin
        len_nxt = LEN_TABLE[wd[7:3]];
      end
      if (wr_status) begin
        on_nxt = (c < REG_CHANNELS) ? wd[c] : 1'b0;
        if (!on_nxt) begin
          len_nxt = 8'd0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        len_r[c]  <= '0;
        on_r[c]   <= 1'b0;
        halt_r[c] <= 1'b0;
      end else begin
        len_r[c]  <= len_nxt;
        on_r[c]   <= on_nxt;
        halt_r[c] <= halt_nxt;
      end
    end
  end

  // Sample channel.
  smp_ctl_t  smp_ctl;
  smp_stat_t smp_stat;

  assign smp_ctl.tick      = is_tick;
  assign smp_ctl.wr_ctrl   = is_wr && (addr == REG_DMC_CTRL);
  assign smp_ctl.wr_len    = is_wr && (addr == REG_DMC_LEN);
  assign smp_ctl.wr_status = wr_status;

  apu_fss_sample u_sample (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (smp_ctl),
    .wdata (wd),
    .stat  (smp_stat)
  );

  // Result assembly; the status byte reflects the state before this item.
  logic [REG_CHANNELS-1:0] len_nz;

  always_comb begin
    len_nz = '0;
    for (int c = 0; c < NUM_STATUS; c++) begin
      len_nz[c] = (len_r[c] != 8'd0);
    end
    out_nxt.read_data    = '0;
    if (rd_status) begin
      out_nxt.read_data = {smp_stat.irq, fflag_r, 1'b0, smp_stat.active, len_nz};
    end
    out_nxt.frame_irq    = fflag_nxt;
    out_nxt.sample_irq   = smp_stat.irq_nxt;
    out_nxt.sample_fetch = smp_stat.fetch;
  end

endmodule

### verif/apu_frame_sequencer_status_unit_test.sv
`timescale 1ns / 1ps

module apu_frame_sequencer_status_unit_test;
  import apu_fss_pkg::*;

  localparam int LEN_CH = NUM_LEN_CH_DEFAULT;
  localparam int RANDOM_PER_PHASE = 160;
  localparam int LONG_HOLD = 300;
  localparam int MAX_REPORTS = 40;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  // Keeps its own copy of the frame sequencer, length counter and sample channel
  // state, predicts the status of each accepted item and checks the results in order.
  class apu_status_tracker;
    logic [15:0] frame_clock;
    logic [2:0] restart_delay;
    bit odd_cycle;
    bit five_step;
    bit irq_inhibit;
    bit frame_irq;
    logic [LEN_CH-1:0][7:0] len_cnt;
    logic [LEN_CH-1:0] ch_on;
    logic [LEN_CH-1:0] ch_halt;
    logic [11:0] bytes_left;
    logic [11:0] sample_len;
    logic [8:0] period_cnt;
    logic [8:0] period_reload;
    logic [3:0] bits_left;
    bit smp_loop;
    bit smp_irq_en;
    bit buf_empty;
    bit smp_irq;
    apu_out_t expected_status[$];
    int mismatches;
    int accepted;
    int checked;
    int byte_loads;
    int frame_irq_results;
    int status_reads;

    // State right after reset.
    function new();
      frame_clock = '0;
      restart_delay = '0;
      odd_cycle = 0;
      five_step = 0;
      irq_inhibit = 0;
      frame_irq = 0;
      len_cnt = '0;
      ch_on = '0;
      ch_halt = '0;
      bytes_left = '0;
      sample_len = '0;
      period_cnt = DMC_PERIOD_RESET;
      period_reload = DMC_PERIOD_RESET;
      bits_left = DMC_BITS_PER_BYTE;
      smp_loop = 0;
      smp_irq_en = 0;
      buf_empty = 1;
      smp_irq = 0;
      mismatches = 0;
      accepted = 0;
      checked = 0;
      byte_loads = 0;
      frame_irq_results = 0;
      status_reads = 0;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // A frame step decrements every running, unhalted length counter.
    function void clock_lengths();
      for (int c = 0; c < LEN_CH; c++) begin
        if (!ch_halt[c] && len_cnt[c] != 0) len_cnt[c] = len_cnt[c] - 8'd1;
      end
    endfunction

    // One sample byte load; the caller makes sure bytes remain.
    function void load_sample_byte();
      buf_empty = 0;
      bytes_left = bytes_left - 12'd1;
      if (bytes_left == 0) begin
        if (smp_loop) begin
          bytes_left = sample_len;
        end else if (smp_irq_en) begin
          smp_irq = 1;
        end
      end
      byte_loads++;
    endfunction

    // Advances the state by one accepted item and queues the status it produces.
    function void step_apu(apu_in_t item);
      apu_out_t want;
      logic [7:0] d;
      logic [7:0] status_byte;
      int ch;
      bit fetched;
      bit restarted;
      d = item.write_data;
      status_byte = '0;
      fetched = 0;
      restarted = 0;
      accepted++;
      case (item.command)
        CMD_TICK: begin
          odd_cycle = !odd_cycle;
          // A pending restart from a frame register write runs out first.
          if (restart_delay != 0) begin
            restart_delay = restart_delay - 3'd1;
            if (restart_delay == 0) begin
              frame_clock = '0;
              restarted = 1;
            end
          end
          if (five_step) begin
            if (!restarted) begin
              frame_clock = frame_clock + 16'd1;
              if (frame_clock == FC5_WRAP) frame_clock = '0;
            end
            if (frame_clock == FC_STEP1 || frame_clock == FC5_STEP2) clock_lengths();
          end else begin
            if (!restarted) begin
              frame_clock = frame_clock + 16'd1;
              if (frame_clock == FC4_WRAP) begin
                frame_clock = '0;
                if (!irq_inhibit) frame_irq = 1;
              end
            end
            if (frame_clock == FC_STEP1 || frame_clock == FC4_STEP2) clock_lengths();
            if (frame_clock >= FC4_IRQ_FROM && !irq_inhibit) frame_irq = 1;
          end
          // The sample timer shifts out one bit per period and needs a byte every eight.
          period_cnt = period_cnt - 9'd1;
          if (period_cnt == 0) begin
            period_cnt = period_reload;
            bits_left = bits_left - 4'd1;
            if (bits_left == 0) begin
              bits_left = DMC_BITS_PER_BYTE;
              buf_empty = 1;
              if (bytes_left != 0) begin
                load_sample_byte();
                fetched = 1;
              end
            end
          end
        end
        CMD_WRITE: begin
          if (item.reg_address < REG_DMC_CTRL) begin
            // Channel register groups: halt flag and length load.
            ch = item.reg_address[4:2];
            if (ch < LEN_CH) begin
              if (item.reg_address[1:0] == CH_REG_HALT) begin
                ch_halt[ch] = (ch == 2) ? d[7] : d[5];
              end else if (item.reg_address[1:0] == CH_REG_LEN && ch_on[ch]) begin
                len_cnt[ch] = LEN_TABLE[d[7:3]];
              end
            end
          end else begin
            case (item.reg_address)
              REG_DMC_CTRL: begin
                smp_irq_en = d[7];
                smp_loop = d[6];
                period_reload = PERIOD_TABLE[d[3:0]];
                if (!smp_irq_en) smp_irq = 0;
              end
              REG_DMC_LEN: begin
                sample_len = {d, 4'h1};
              end
              REG_STATUS: begin
                for (int c = 0; c < LEN_CH; c++) begin
                  ch_on[c] = (c < REG_CHANNELS) && d[c];
                  if (!ch_on[c]) len_cnt[c] = '0;
                end
                smp_irq = 0;
                if (!d[4]) begin
                  bytes_left = '0;
                end else if (bytes_left == 0) begin
                  bytes_left = sample_len;
                  if (buf_empty && bytes_left != 0) begin
                    load_sample_byte();
                    fetched = 1;
                  end
                end
              end
              REG_FRAME: begin
                five_step = d[7];
                irq_inhibit = d[6];
                if (irq_inhibit) frame_irq = 0;
                restart_delay = odd_cycle ? FRAME_DELAY_ODD : FRAME_DELAY_EVEN;
                if (five_step) clock_lengths();
              end
              default: begin
              end
            endcase
          end
        end
        CMD_READ: begin
          // Only the status register reads back, and reading it clears the frame flag.
          if (item.reg_address == REG_STATUS) begin
            status_byte[7] = smp_irq;
            status_byte[6] = frame_irq;
            status_byte[4] = (bytes_left != 0);
            for (int c = 0; c < LEN_CH && c < REG_CHANNELS; c++) begin
              if (len_cnt[c] != 0) status_byte[c] = 1'b1;
            end
            frame_irq = 0;
            status_reads++;
          end
        end
        default: begin
        end
      endcase
      want.read_data = status_byte;
      want.frame_irq = frame_irq;
      want.sample_irq = smp_irq;
      want.sample_fetch = fetched;
      if (frame_irq) frame_irq_results++;
      expected_status.push_back(want);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // Compares one result transfer with the oldest predicted status.
    function void check_status(apu_out_t got);
      apu_out_t want;
      if (expected_status.size() == 0) begin
        report("unexpected result", 0, got);
        return;
      end
      want = expected_status.pop_front();
      checked++;
      if (got.read_data !== want.read_data) report("read_data", want.read_data, got.read_data);
      if (got.frame_irq !== want.frame_irq) report("frame_irq", want.frame_irq, got.frame_irq);
      if (got.sample_irq !== want.sample_irq) begin
        report("sample_irq", want.sample_irq, got.sample_irq);
      end
      if (got.sample_fetch !== want.sample_fetch) begin
        report("sample_fetch", want.sample_fetch, got.sample_fetch);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  apu_in_t in_data;
  logic out_valid;
  logic out_ready;
  apu_out_t out_data;

  int sender_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int unsigned cycle_count;
  apu_status_tracker tracker = new();

  apu_frame_sequencer_status_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every result transfer is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_status(out_data);
  end

  // Cycle budget for the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run timed out after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  // Offers one item, with random idle cycles first; starts and ends at a falling edge.
  task automatic drive_item(input apu_in_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.step_apu(item);
    @(negedge clk);
  endtask

  task automatic send_cmd(input cmd_e cmd, input logic [4:0] addr, input logic [7:0] data);
    apu_in_t item;
    item.command = cmd;
    item.reg_address = addr;
    item.write_data = data;
    drive_item(item);
  endtask

  // Runs the sequencer forward, with an optional status read every so many ticks.
  task automatic run_ticks(input int count, input int read_every);
    for (int i = 1; i <= count; i++) begin
      send_cmd(CMD_TICK, 5'($urandom), 8'($urandom));
      if (read_every != 0 && i % read_every == 0) send_cmd(CMD_READ, REG_STATUS, 8'($urandom));
    end
  endtask

  // Mostly ticks, register writes and status reads; some stray accesses and no-ops.
  function automatic apu_in_t random_item();
    apu_in_t item;
    int unsigned pick;
    pick = $urandom_range(99);
    item.reg_address = 5'($urandom);
    item.write_data = 8'($urandom);
    if (pick < 40) begin
      item.command = CMD_TICK;
    end else if (pick < 70) begin
      item.command = CMD_WRITE;
      case ($urandom_range(11))
        8: begin
          item.reg_address = REG_DMC_CTRL;
          if ($urandom_range(1)) item.write_data[3:0] = 4'hF;
        end
        9: begin
          item.reg_address = REG_DMC_LEN;
          if ($urandom_range(1)) item.write_data = 8'($urandom_range(3));
        end
        10: item.reg_address = REG_STATUS;
        11: item.reg_address = REG_FRAME;
        default: begin
          item.reg_address = {3'($urandom_range(3)), $urandom_range(1) ? CH_REG_LEN : CH_REG_HALT};
        end
      endcase
    end else if (pick < 85) begin
      item.command = CMD_READ;
      item.reg_address = REG_STATUS;
    end else if (pick < 94) begin
      item.command = $urandom_range(1) ? CMD_WRITE : CMD_READ;
    end else begin
      item.command = CMD_NOP;
    end
    return item;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) begin
        run_ticks($urandom_range(4, 1), 0);
      end else begin
        drive_item(random_item());
      end
    end
  endtask

  // The sender pauses until every predicted status has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items: reset status, zero sample length, table extremes, both halt
    // bit positions, an immediate byte load with interrupt, ignored accesses.
    send_cmd(CMD_READ, REG_STATUS, 8'h00);
    send_cmd(CMD_WRITE, REG_STATUS, 8'h1F);
    send_cmd(CMD_READ, REG_STATUS, 8'hFF);
    send_cmd(CMD_WRITE, 5'h03, 8'hF8);
    send_cmd(CMD_WRITE, 5'h07, 8'h08);
    send_cmd(CMD_WRITE, 5'h0B, 8'h00);
    send_cmd(CMD_WRITE, 5'h0F, 8'hFF);
    send_cmd(CMD_WRITE, 5'h00, 8'h20);
    send_cmd(CMD_WRITE, 5'h08, 8'h80);
    send_cmd(CMD_WRITE, REG_FRAME, 8'h80);
    send_cmd(CMD_READ, REG_STATUS, 8'h00);
    send_cmd(CMD_WRITE, REG_DMC_CTRL, 8'hCF);
    send_cmd(CMD_WRITE, REG_DMC_LEN, 8'hFF);
    send_cmd(CMD_WRITE, REG_DMC_LEN, 8'h00);
    send_cmd(CMD_WRITE, REG_DMC_CTRL, 8'h8F);
    send_cmd(CMD_WRITE, REG_STATUS, 8'h10);
    send_cmd(CMD_READ, REG_STATUS, 8'h00);
    send_cmd(CMD_READ, 5'h14, 8'h00);
    send_cmd(CMD_NOP, 5'h1F, 8'hFF);
    send_cmd(CMD_WRITE, 5'h1F, 8'hFF);
    send_cmd(CMD_WRITE, 5'h14, 8'hAA);
    send_cmd(CMD_WRITE, REG_FRAME, 8'h40);
    send_cmd(CMD_WRITE, REG_DMC_CTRL, 8'h00);
    run_ticks(2, 0);

    // Short tick runs in both frame modes: a looping sample, short length counters,
    // one halted, and delayed restarts after each frame register write.
    send_cmd(CMD_WRITE, REG_DMC_CTRL, 8'h4F);
    send_cmd(CMD_WRITE, REG_DMC_LEN, 8'h01);
    send_cmd(CMD_WRITE, REG_STATUS, 8'h1F);
    send_cmd(CMD_WRITE, 5'h00, 8'h00);
    send_cmd(CMD_WRITE, 5'h08, 8'h00);
    send_cmd(CMD_WRITE, 5'h0C, 8'h20);
    send_cmd(CMD_WRITE, 5'h03, 8'h18);
    send_cmd(CMD_WRITE, 5'h07, 8'h00);
    send_cmd(CMD_WRITE, 5'h0B, 8'h18);
    send_cmd(CMD_WRITE, 5'h0F, 8'h18);
    send_cmd(CMD_WRITE, REG_FRAME, 8'h00);
    run_ticks(40, 10);
    send_cmd(CMD_WRITE, REG_FRAME, 8'h80);
    run_ticks(40, 10);
    send_cmd(CMD_WRITE, REG_FRAME, 8'h00);
    run_ticks(8, 0);
    send_cmd(CMD_READ, REG_STATUS, 8'h00);
    run_ticks(20, 0);

    // Random items with no idling; the receiver holds off long enough to stall the input.
    hold_requests++;
    run_random(RANDOM_PER_PHASE);
    wait_for_results();

    sender_idle_pct = 86;
    recv_stall_pct = 0;
    run_random(RANDOM_PER_PHASE);
    wait_for_results();

    sender_idle_pct = 0;
    recv_stall_pct = 86;
    run_random(RANDOM_PER_PHASE);
    wait_for_results();

    sender_idle_pct = 10;
    recv_stall_pct = 10;
    run_random(RANDOM_PER_PHASE);
    wait_for_results();

    // Give any stray result time to show up.
    repeat (8) @(posedge clk);
    $display("Run covered %0d input transfers and %0d checked results, %0d status reads.",
             tracker.accepted, tracker.checked, tracker.status_reads);
    $display("Sample byte loads: %0d; results with the frame interrupt high: %0d.",
             tracker.byte_loads, tracker.frame_irq_results);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/apu_fss_pkg.sv
rtl/apu_fss_sample.sv
rtl/apu_frame_sequencer_status_unit.sv
verif/apu_frame_sequencer_status_unit_test.sv
